### hw/rtl/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg: shared types and constants of the Sobel edge magnitude unit
// Pixel and window types, the square root cell record and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sem_pkg;

  localparam int IMG_W_W     = 11;
  localparam int IMG_H_W     = 13;
  localparam int ROW_W       = 12;
  localparam int THR_W       = 8;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST    = 11'd640;
  localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST   = 13'd480;
  localparam logic [THR_W-1:0]   EDGE_THRESHOLD_RST = 8'd80;
  localparam logic [IMG_H_W-1:0] MAX_HEIGHT         = 13'd4096;

  localparam int RAD_W       = 16;
  localparam int REM_W       = 10;
  localparam int ROOT_W      = 8;
  localparam int SQRT_STAGES = 8;

  typedef logic [7:0] pix_t;
  typedef logic [2:0][2:0][7:0] win_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic eof;
    win_t win;
  } req_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic              eof;
    logic              sat;
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqc_t;

endpackage

### hw/rtl/sem_window.sv
// ----------------------------------------------------------------------------
// sem_window: line stores, 3x3 window and result sequencer
// Tracks column and row, keeps two line stores, slides the window and hands
// up to four windows per pixel, one a cycle while the output advances, to the
// gradient stage.
`timescale 1ns / 1ps

module sem_window #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  sem_pkg::pix_t                in_pixel,
  input  logic [sem_pkg::IMG_W_W-1:0]  cfg_width,
  input  logic [sem_pkg::IMG_H_W-1:0]  cfg_height,
  input  logic                         advance,
  output sem_pkg::req_t                req
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > sem_pkg::IMG_W_W) ? WW : sem_pkg::IMG_W_W;
  localparam int HW   = sem_pkg::IMG_H_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]               state_r;
  logic [CW-1:0]            col_r, col_nxt;
  logic [sem_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [3:0]               pend_r, pend_load, pend_clr;

  logic [CMPW-1:0]          w_ext;
  logic [WW-1:0]            eff_w, c_inc;
  logic [HW-1:0]            eff_h, r_pre, r_inc;
  logic [CW-1:0]            c_eff;
  logic [sem_pkg::ROW_W-1:0] r_eff;
  logic                     accept;

  logic [CW-1:0]            c_q;
  sem_pkg::pix_t            p_q, lo_q, up_q, a_pix;
  logic                     f_r1, f_r2, f_c0, f_c1, f_clast, f_rlast;
  sem_pkg::win_t            win_r, win_nxt, sel_win;
  logic                     sel_eof;

  sem_pkg::pix_t            upper_mem [MAX_WIDTH];
  sem_pkg::pix_t            lower_mem [MAX_WIDTH];

  function automatic sem_pkg::win_t bottom_win(input sem_pkg::win_t w);
    sem_pkg::win_t t;
    t[0] = w[1];
    t[1] = w[2];
    t[2] = w[2];
    return t;
  endfunction

  function automatic sem_pkg::win_t rep_win(input sem_pkg::win_t w);
    sem_pkg::win_t t;
    for (int i = 0; i < 3; i++) begin
      t[i][0] = w[i][1];
      t[i][1] = w[i][2];
      t[i][2] = w[i][2];
    end
    return t;
  endfunction

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // clamp sizes, wrap counts left past a smaller size, then advance
  always_comb begin
    w_ext = CMPW'(cfg_width);
    if (w_ext < CMPW'(2)) begin
      eff_w = WW'(2);
    end else if (w_ext > CMPW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(w_ext);
    end
    if (cfg_height < HW'(2)) begin
      eff_h = HW'(2);
    end else if (cfg_height > sem_pkg::MAX_HEIGHT) begin
      eff_h = sem_pkg::MAX_HEIGHT;
    end else begin
      eff_h = cfg_height;
    end

    if (WW'(col_r) >= eff_w) begin
      c_eff = '0;
      r_pre = HW'(row_r) + HW'(1);
    end else begin
      c_eff = col_r;
      r_pre = HW'(row_r);
    end
    if (r_pre >= eff_h) begin
      r_pre = '0;
    end
    r_eff = r_pre[sem_pkg::ROW_W-1:0];

    c_inc = WW'(c_eff) + WW'(1);
    r_inc = HW'(r_eff) + HW'(1);
    if (r_inc >= eff_h) begin
      r_inc = '0;
    end
    if (c_inc >= eff_w) begin
      col_nxt = '0;
      row_nxt = r_inc[sem_pkg::ROW_W-1:0];
    end else begin
      col_nxt = c_inc[CW-1:0];
      row_nxt = r_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lo_q <= lower_mem[c_eff];
      up_q <= upper_mem[c_eff];
    end
    if (state_r == S_LOAD) begin
      lower_mem[c_q] <= p_q;
      upper_mem[c_q] <= lo_q;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      c_q     <= c_eff;
      p_q     <= in_pixel;
      f_r1    <= (r_eff != '0);
      f_r2    <= (r_eff >= sem_pkg::ROW_W'(2));
      f_c0    <= (c_eff == '0);
      f_c1    <= (c_eff != '0);
      f_clast <= (WW'(c_eff) == (eff_w - WW'(1)));
      f_rlast <= (HW'(r_eff) == (eff_h - HW'(1)));
    end
  end

  assign a_pix = f_r2 ? up_q : lo_q;

  always_comb begin
    win_nxt = win_r;
    if (f_c0) begin
      for (int i = 0; i < 3; i++) begin
        win_nxt[0][i] = a_pix;
        win_nxt[1][i] = lo_q;
        win_nxt[2][i] = p_q;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        win_nxt[i][0] = win_r[i][1];
        win_nxt[i][1] = win_r[i][2];
      end
      win_nxt[0][2] = a_pix;
      win_nxt[1][2] = lo_q;
      win_nxt[2][2] = p_q;
    end
  end

  assign pend_load = {f_r1 && f_clast && f_rlast, f_r1 && f_clast,
                      f_r1 && f_c1 && f_rlast, f_r1 && f_c1};
  assign pend_clr  = pend_r & (pend_r - 4'd1);

  always_comb begin
    sel_eof = 1'b0;
    if (pend_r[0]) begin
      sel_win = win_r;
    end else if (pend_r[1]) begin
      sel_win = bottom_win(win_r);
    end else if (pend_r[2]) begin
      sel_win = rep_win(win_r);
    end else begin
      sel_win = bottom_win(rep_win(win_r));
      sel_eof = 1'b1;
    end
    req.valid = (state_r == S_EMIT);
    req.last  = (pend_clr == '0);
    req.eof   = sel_eof;
    req.win   = sel_win;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      pend_r  <= '0;
      win_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            col_r   <= col_nxt;
            row_r   <= row_nxt;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          win_r   <= win_nxt;
          pend_r  <= pend_load;
          state_r <= (pend_load != '0) ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (advance) begin
            pend_r <= pend_clr;
            if (pend_clr == '0) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (pend_r != '0))
    else $error("window emit without pending result");

  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_LOAD))
    else $error("accepted pixel not loaded");

endmodule

### hw/rtl/sem_gradient.sv
// ----------------------------------------------------------------------------
// sem_gradient: Sobel sums and squared magnitude
// Forms absolute dx and dy, squares them and adds, then seeds the square
// root chain with a saturation flag and a 16-bit radicand.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sem_gradient (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  sem_pkg::req_t req,
  output sem_pkg::sqc_t seed
);

  logic [9:0]  xp, xn, yp, yn, adx, ady;
  logic [9:0]  adx_r, ady_r;
  logic        v1_r, l1_r, e1_r;
  logic [19:0] sqx, sqy, sqx_r, sqy_r;
  logic        v2_r, l2_r, e2_r;
  logic [20:0] sum;
  sem_pkg::sqc_t seed_r, seed_nxt;

  always_comb begin
    xp  = 10'(req.win[0][2]) + {1'b0, req.win[1][2], 1'b0} + 10'(req.win[2][2]);
    xn  = 10'(req.win[0][0]) + {1'b0, req.win[1][0], 1'b0} + 10'(req.win[2][0]);
    yp  = 10'(req.win[2][0]) + {1'b0, req.win[2][1], 1'b0} + 10'(req.win[2][2]);
    yn  = 10'(req.win[0][0]) + {1'b0, req.win[0][1], 1'b0} + 10'(req.win[0][2]);
    adx = (xp >= xn) ? (xp - xn) : (xn - xp);
    ady = (yp >= yn) ? (yp - yn) : (yn - yp);
  end

  assign sqx = 20'(adx_r) * 20'(adx_r);
  assign sqy = 20'(ady_r) * 20'(ady_r);
  assign sum = 21'(sqx_r) + 21'(sqy_r);

  always_comb begin
    seed_nxt.valid = v2_r;
    seed_nxt.last  = l2_r;
    seed_nxt.eof   = e2_r;
    seed_nxt.sat   = |sum[20:16];
    seed_nxt.rad   = sum[15:0];
    seed_nxt.rem   = '0;
    seed_nxt.root  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      seed_r.valid <= 1'b0;
    end else if (advance) begin
      v1_r   <= req.valid;
      l1_r   <= req.last;
      e1_r   <= req.eof;
      adx_r  <= adx;
      ady_r  <= ady;
      v2_r   <= v1_r;
      l2_r   <= l1_r;
      e2_r   <= e1_r;
      sqx_r  <= sqx;
      sqy_r  <= sqy;
      seed_r <= seed_nxt;
    end
  end

  assign seed = seed_r;

endmodule

### hw/rtl/sem_sqrt_cell.sv
// ----------------------------------------------------------------------------
// sem_sqrt_cell: one digit of the integer square root
// Takes the next two radicand bits, tries the partial root and passes the
// remainder, root and tags to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sem_sqrt_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  sem_pkg::sqc_t cin,
  output sem_pkg::sqc_t cout
);

  localparam int WKW = sem_pkg::REM_W + 2;

  logic [WKW-1:0] work, trial, diff;
  sem_pkg::sqc_t  cell_r, cell_nxt;

  assign work  = {cin.rem, cin.rad[sem_pkg::RAD_W-1 -: 2]};
  assign trial = {{(WKW - sem_pkg::ROOT_W - 2){1'b0}}, cin.root, 2'b01};
  assign diff  = work - trial;

  always_comb begin
    cell_nxt     = cin;
    cell_nxt.rad = {cin.rad[sem_pkg::RAD_W-3:0], 2'b00};
    if (work >= trial) begin
      cell_nxt.rem  = diff[sem_pkg::REM_W-1:0];
      cell_nxt.root = {cin.root[sem_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      cell_nxt.rem  = work[sem_pkg::REM_W-1:0];
      cell_nxt.root = {cin.root[sem_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (advance) begin
      cell_r <= cell_nxt;
    end
  end

  assign cout = cell_r;

endmodule

### hw/rtl/sobel_edge_magnitude_unit.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_unit: streaming 3x3 Sobel gradient magnitude
// A pixel passes the line store read and window update, then hands its 0 to 4
// results into the chain, one window a cycle while the output advances.
// A result then passes the gradient stage, root cells and output register.
// Synchronous reset clears control and restores the default registers;
// line stores are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sobel_edge_magnitude_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_pixel,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_edge_value,
  output logic                            out_last_of_run,
  output logic                            out_end_of_frame,
  input  logic                            cfg_we,
  input  logic [sem_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int N = sem_pkg::SQRT_STAGES;

  logic [sem_pkg::IMG_W_W-1:0] width_r;
  logic [sem_pkg::IMG_H_W-1:0] height_r;
  logic [sem_pkg::THR_W-1:0]   thr_r;
  logic                        advance;
  sem_pkg::req_t               req;
  sem_pkg::sqc_t               chain [N+1];
  logic [7:0]                  mag, edge_nxt;
  logic                        out_valid_r, out_last_r, out_eof_r;
  logic [7:0]                  out_edge_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= sem_pkg::IMAGE_WIDTH_RST;
      height_r <= sem_pkg::IMAGE_HEIGHT_RST;
      thr_r    <= sem_pkg::EDGE_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sem_pkg::REG_IMAGE_WIDTH:    width_r  <= cfg_wdata[sem_pkg::IMG_W_W-1:0];
        sem_pkg::REG_IMAGE_HEIGHT:   height_r <= cfg_wdata[sem_pkg::IMG_H_W-1:0];
        sem_pkg::REG_EDGE_THRESHOLD: thr_r    <= cfg_wdata[sem_pkg::THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign advance = !out_valid_r || !out_stall;

  sem_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_pixel   (in_pixel),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .advance    (advance),
    .req        (req)
  );

  sem_gradient u_gradient (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .req     (req),
    .seed    (chain[0])
  );

  for (genvar g = 0; g < N; g++) begin : g_cell
    sem_sqrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .cin     (chain[g]),
      .cout    (chain[g+1])
    );
  end

  assign mag      = chain[N].sat ? 8'hFF : chain[N].root;
  assign edge_nxt = (mag < thr_r) ? 8'd0 : mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= chain[N].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && chain[N].valid) begin
      out_edge_r <= edge_nxt;
      out_last_r <= chain[N].last;
      out_eof_r  <= chain[N].eof;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_edge_value   = out_edge_r;
  assign out_last_of_run  = out_last_r;
  assign out_end_of_frame = out_eof_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_eof_r) |-> out_last_r)
    else $error("frame end result not last of its run");

  assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(chain[N]))
    else $error("root chain moved while output held");

endmodule

### verif/sobel_edge_magnitude_unit_tb.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_unit_tb: self-checking bench of the Sobel magnitude unit
// Streams grey frames of many sizes and thresholds through the unit, with
// bursty input and an output side that stalls on its own pattern. A line
// store and window model inside the scoreboard predicts every magnitude and
// its end-of-run and end-of-frame flags, and each result is checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sobel_edge_magnitude_unit_tb;

  localparam logic [sem_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int LINE_DEPTH   = 1024;
  localparam int HEIGHT_CAP   = 4096;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 220;
  localparam int TALL_ITEMS   = 40;

  typedef logic [7:0] grid_t [3][3];

  typedef struct {
    logic [7:0] magnitude;
    logic       last_of_run;
    logic       end_of_frame;
  } edge_result_t;

  typedef enum int {PIX_UNIFORM, PIX_SMOOTH, PIX_BINARY, PIX_EXTREME} pix_mode_t;

  class edge_scoreboard;
    int unsigned  width_reg;
    int unsigned  height_reg;
    int unsigned  thr_reg;
    logic [7:0]   upper_line [LINE_DEPTH];
    logic [7:0]   lower_line [LINE_DEPTH];
    grid_t        win;
    int unsigned  col;
    int unsigned  row;
    edge_result_t expected_edges [$];
    int unsigned  errors;
    int unsigned  reported;

    function new();
      width_reg  = sem_pkg::IMAGE_WIDTH_RST;
      height_reg = sem_pkg::IMAGE_HEIGHT_RST;
      thr_reg    = sem_pkg::EDGE_THRESHOLD_RST;
      foreach (upper_line[i]) begin
        upper_line[i] = 8'd0;
        lower_line[i] = 8'd0;
      end
      foreach (win[i, j]) win[i][j] = 8'd0;
      col      = 0;
      row      = 0;
      errors   = 0;
      reported = 0;
    endfunction

    function void write_reg(logic [sem_pkg::CFG_IDX_W-1:0] idx,
                            logic [sem_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        sem_pkg::REG_IMAGE_WIDTH:    width_reg  = val[sem_pkg::IMG_W_W-1:0];
        sem_pkg::REG_IMAGE_HEIGHT:   height_reg = val[sem_pkg::IMG_H_W-1:0];
        sem_pkg::REG_EDGE_THRESHOLD: thr_reg    = val[sem_pkg::THR_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      if (width_reg < 2) return 2;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg < 2) return 2;
      if (height_reg > HEIGHT_CAP) return HEIGHT_CAP;
      return height_reg;
    endfunction

    function bit mid_frame();
      return col != 0 || row != 0;
    endfunction

    function int unsigned pixels_to_frame_end();
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      w = eff_width();
      h = eff_height();
      c = col;
      r = row;
      if (c >= w) begin
        c = 0;
        r++;
      end
      if (r >= h) r = 0;
      return (h - r) * w - c;
    endfunction

    function int unsigned grad_mag(grid_t g);
      int          dx;
      int          dy;
      int unsigned sq;
      int unsigned m;
      dx = int'(g[0][2]) + 2 * int'(g[1][2]) + int'(g[2][2])
         - int'(g[0][0]) - 2 * int'(g[1][0]) - int'(g[2][0]);
      dy = int'(g[2][0]) + 2 * int'(g[2][1]) + int'(g[2][2])
         - int'(g[0][0]) - 2 * int'(g[0][1]) - int'(g[0][2]);
      sq = dx * dx + dy * dy;
      m = 0;
      while (m < 255 && (m + 1) * (m + 1) <= sq) m++;
      if (m < thr_reg) m = 0;
      return m;
    endfunction

    // replicate the bottom row below the last image row
    function grid_t bottom_of(grid_t g);
      grid_t t;
      for (int i = 0; i < 3; i++) begin
        t[0][i] = g[1][i];
        t[1][i] = g[2][i];
        t[2][i] = g[2][i];
      end
      return t;
    endfunction

    function void note_pixel(logic [7:0] p);
      int unsigned  w;
      int unsigned  h;
      logic [7:0]   lo;
      logic [7:0]   up;
      logic [7:0]   above;
      grid_t        rep;
      edge_result_t batch [$];
      w = eff_width();
      h = eff_height();
      if (col >= w) begin
        col = 0;
        row++;
      end
      if (row >= h) row = 0;

      lo    = lower_line[col];
      up    = upper_line[col];
      above = (row >= 2) ? up : lo;
      upper_line[col] = lo;
      lower_line[col] = p;

      for (int i = 0; i < 3; i++) begin
        if (col == 0) begin
          win[0][i] = above;
          win[1][i] = lo;
          win[2][i] = p;
        end else begin
          win[i][0] = win[i][1];
          win[i][1] = win[i][2];
        end
      end
      if (col != 0) begin
        win[0][2] = above;
        win[1][2] = lo;
        win[2][2] = p;
      end

      if (row >= 1 && col >= 1) begin
        batch.push_back(edge_result_t'{8'(grad_mag(win)), 1'b0, 1'b0});
        if (row == h - 1)
          batch.push_back(edge_result_t'{8'(grad_mag(bottom_of(win))), 1'b0, 1'b0});
      end
      if (row >= 1 && col == w - 1) begin
        for (int i = 0; i < 3; i++) begin
          rep[i][0] = win[i][1];
          rep[i][1] = win[i][2];
          rep[i][2] = win[i][2];
        end
        batch.push_back(edge_result_t'{8'(grad_mag(rep)), 1'b0, 1'b0});
        if (row == h - 1)
          batch.push_back(edge_result_t'{8'(grad_mag(bottom_of(rep))), 1'b0, 1'b1});
      end

      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end

      if (batch.size() > 0) batch[batch.size() - 1].last_of_run = 1'b1;
      foreach (batch[i]) expected_edges.push_back(batch[i]);
    endfunction

    function void check_result(logic [7:0] mag, logic last_of_run, logic end_of_frame);
      edge_result_t exp_r;
      if (expected_edges.size() == 0) begin
        errors++;
        if (reported < 10)
          $display("unexpected result: edge %0d last %b eof %b",
                   mag, last_of_run, end_of_frame);
        reported++;
        return;
      end
      exp_r = expected_edges.pop_front();
      if (mag !== exp_r.magnitude || last_of_run !== exp_r.last_of_run ||
          end_of_frame !== exp_r.end_of_frame) begin
        errors++;
        if (reported < 10)
          $display("mismatch: expected edge %0d last %b eof %b, got edge %0d last %b eof %b",
                   exp_r.magnitude, exp_r.last_of_run, exp_r.end_of_frame,
                   mag, last_of_run, end_of_frame);
        reported++;
      end
    endfunction

    function void close_out();
      if (expected_edges.size() != 0) begin
        errors++;
        $display("%0d expected results never arrived", expected_edges.size());
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic [7:0]                     in_pixel;
  logic                           out_valid;
  logic                           out_stall;
  logic [7:0]                     out_edge_value;
  logic                           out_last_of_run;
  logic                           out_end_of_frame;
  logic                           cfg_we;
  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sem_pkg::CFG_DATA_W-1:0] cfg_wdata;

  edge_scoreboard sb;
  int unsigned    items_sent;
  bit             hold_req;

  sobel_edge_magnitude_unit #(
    .MAX_WIDTH(LINE_DEPTH)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_edge_value   (out_edge_value),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_frame (out_end_of_frame),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic write_reg_port(logic [sem_pkg::CFG_IDX_W-1:0] idx,
                                logic [sem_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic program_frame(int unsigned w, int unsigned h, int unsigned thr);
    write_reg_port(sem_pkg::REG_IMAGE_WIDTH, sem_pkg::CFG_DATA_W'(w));
    write_reg_port(sem_pkg::REG_IMAGE_HEIGHT, sem_pkg::CFG_DATA_W'(h));
    write_reg_port(sem_pkg::REG_EDGE_THRESHOLD, sem_pkg::CFG_DATA_W'(thr));
    cfg_we <= 1'b0;
  endtask

  // hold until every expected result is back, then let the pipeline drain
  task automatic wait_idle();
    while (sb.expected_edges.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_pixel(logic [7:0] p);
    in_valid <= 1'b1;
    in_pixel <= p;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    sb.note_pixel(p);
    items_sent++;
  endtask

  task automatic send_list(logic [7:0] pix [$]);
    foreach (pix[i]) send_pixel(pix[i]);
    in_valid <= 1'b0;
    wait_idle();
  endtask

  task automatic feed(int unsigned n, pix_mode_t mode, bit steady);
    int unsigned burst;
    int unsigned gap;
    logic [7:0]  px;
    burst = 0;
    px    = 8'($urandom_range(0, 255));
    repeat (n) begin
      if (!steady && burst == 0) begin
        burst = $urandom_range(1, 24);
        gap   = $urandom_range(0, 6);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      case (mode)
        PIX_UNIFORM: px = 8'($urandom_range(0, 255));
        PIX_SMOOTH:  px = px + 8'($urandom_range(0, 16)) - 8'd8;
        PIX_BINARY:  px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default: begin
          if ($urandom_range(0, 3) == 0) px = 8'($urandom_range(0, 255));
          else if ($urandom_range(0, 1) != 0) px = 8'hFF - 8'($urandom_range(0, 3));
          else px = 8'($urandom_range(0, 3));
        end
      endcase
      send_pixel(px);
      if (burst != 0) burst--;
    end
    in_valid <= 1'b0;
  endtask

  function automatic int unsigned pick_threshold();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(0, 180);
    endcase
  endfunction

  // output side: own stall pattern, plus one long hold-off on request
  initial begin
    int unsigned tick;
    int unsigned mode;
    tick = 0;
    mode = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (tick % 50 == 0) mode = $urandom_range(0, 3);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (tick % 3 == 0);
        endcase
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result(out_edge_value, out_last_of_run, out_end_of_frame);
  end

  initial begin
    #(20_000_000);
    $display("sobel_edge_magnitude_unit_tb: FAIL");
    $finish;
  end

  initial begin
    logic [7:0]  dir [$];
    int unsigned random_start;
    int unsigned w;
    int unsigned h;
    int unsigned wmax;
    int unsigned n;
    sb         = new();
    items_sent = 0;
    hold_req   = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_pixel   = 8'd0;
    cfg_we     = 1'b0;
    cfg_index  = sem_pkg::REG_IMAGE_WIDTH;
    cfg_wdata  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // clamped sizes, zero threshold, extreme pixels
    program_frame(1, 0, 0);
    dir = '{8'd0, 8'd255, 8'd255, 8'd0};
    send_list(dir);

    // write past the register list: ignored
    write_reg_port(REG_UNUSED, 13'h1FFF);
    cfg_we <= 1'b0;

    program_frame(2, 2, 255);
    dir = '{8'd255, 8'd0, 8'd0, 8'd255};
    send_list(dir);

    // shrink the width mid-frame: the row wraps early
    program_frame(4, 3, 0);
    dir = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0};
    send_list(dir);
    program_frame(2, 3, 40);
    dir = '{8'd128, 8'd1};
    send_list(dir);

    program_frame(3, 3, 128);
    dir = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
    send_list(dir);

    // long output hold-off while input keeps coming
    program_frame(16, 8, $urandom_range(0, 120));
    hold_req = 1'b1;
    feed(128, PIX_UNIFORM, 1'b1);
    wait_idle();

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      wmax = sb.mid_frame() ? sb.eff_width() : 12;
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, wmax);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
      program_frame(w, h, pick_threshold());
      n = sb.pixels_to_frame_end();
      if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
      feed(n, pix_mode_t'($urandom_range(0, 3)), $urandom_range(0, 3) == 0);
      wait_idle();
    end

    if (sb.mid_frame()) begin
      feed(sb.pixels_to_frame_end(), PIX_UNIFORM, 1'b0);
      wait_idle();
    end

    // oversized height clamps: narrow rows of a tall frame
    program_frame(0, 8191, pick_threshold());
    feed(TALL_ITEMS, PIX_SMOOTH, 1'b1);

    wait_idle();
    sb.close_out();
    if (sb.errors == 0)
      $display("sobel_edge_magnitude_unit_tb: PASS");
    else
      $display("sobel_edge_magnitude_unit_tb: FAIL");
    $finish;
  end

endmodule
